// ===== rtl/image_rotate_nearest_defines.svh =====
// ----------------------------------------------------------------------------
// image_rotate_nearest assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef IMAGE_ROTATE_NEAREST_DEFINES_SVH
`define IMAGE_ROTATE_NEAREST_DEFINES_SVH

// When ante holds at a clock edge, cons must follow (cons may carry a delay).
`define IRN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The condition must never be seen at a clock edge.
`define IRN_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/irn_pkg.sv =====
// ----------------------------------------------------------------------------
// irn_pkg
// Types and fixed constants of the nearest-neighbor image rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package irn_pkg;

  localparam int PIX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DR_W       = 11;
  localparam int TRIG_W     = 16;
  localparam int PROD_W     = DR_W + TRIG_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_REQ  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OLD_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_Q      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN_Q      = 3'd5;

  typedef struct packed {
    logic       mode;
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } irn_in_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       inside_res;
  } irn_out_t;

  typedef struct packed {
    logic [9:0]               old_height;
    logic [9:0]               old_width;
    logic [10:0]              new_height;
    logic [10:0]              new_width;
    logic signed [TRIG_W-1:0] cos_q;
    logic signed [TRIG_W-1:0] sin_q;
  } irn_cfg_t;

  // Per-beat control that leaves the address pipeline.
  typedef struct packed {
    logic req;
    logic wr;
    logic hit;
  } irn_ctl_t;

  localparam irn_cfg_t CFG_RESET = '{
    old_height: 10'd512,
    old_width:  10'd512,
    new_height: 11'd512,
    new_width:  11'd512,
    cos_q:      16'sd16384,
    sin_q:      16'sd0
  };

endpackage

`default_nettype wire

// ===== rtl/irn_map.sv =====
// ----------------------------------------------------------------------------
// irn_map
// Four-stage address pipeline: center offsets, rotation products, sums,
// then truncation toward zero and the bounds check that yields the index;
// load beats keep their own row and column as the index.
`default_nettype none

module irn_map import irn_pkg::*; #(
  parameter int MAX_SRC_ROWS   = 512,
  parameter int MAX_SRC_COLS   = 512,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int RW = $clog2(MAX_SRC_ROWS),
  localparam int CW = $clog2(MAX_SRC_COLS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire irn_in_t       in_data,
  input  wire irn_cfg_t      cfg,
  output irn_ctl_t           ctl_o,
  output logic [RW-1:0]      x_idx_o,
  output logic [CW-1:0]      y_idx_o,
  output logic [PIX_W-1:0]   pix_o
);

  localparam int F    = TRIG_FRAC_BITS;
  localparam int SW   = ((PROD_W > F + 9) ? PROD_W : F + 9) + 2;
  localparam int FW   = SW - F;
  localparam int XW   = (FW > RW + 1) ? FW : RW + 1;
  localparam int YW   = (FW > CW + 1) ? FW : CW + 1;
  localparam int LRW  = (RW + 1 > 10) ? RW + 1 : 10;
  localparam int LCW  = (CW + 1 > 10) ? CW + 1 : 10;

  // Stage 0: accepted beat, offsets from the output center.
  logic                    req0_r, wr0_r;
  logic [RW-1:0]           ri0_r;
  logic [CW-1:0]           ci0_r;
  logic [PIX_W-1:0]        pix0_r;
  logic signed [DR_W-1:0]  dr0_r, dc0_r;

  logic [LRW-1:0]          row_ext;
  logic [LCW-1:0]          col_ext;
  logic                    ld_ok;
  logic signed [DR_W-1:0]  dr_nxt, dc_nxt;

  always_comb begin
    row_ext = LRW'(in_data.row);
    col_ext = LCW'(in_data.col);
    ld_ok   = (row_ext < LRW'(MAX_SRC_ROWS)) && (col_ext < LCW'(MAX_SRC_COLS));
    dr_nxt  = signed'({1'b0, in_data.row}) - signed'({1'b0, cfg.new_height[10:1]});
    dc_nxt  = signed'({1'b0, in_data.col}) - signed'({1'b0, cfg.new_width[10:1]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req0_r <= 1'b0;
      wr0_r  <= 1'b0;
    end else begin
      req0_r <= accept && (in_data.mode == MODE_REQ);
      wr0_r  <= accept && (in_data.mode == MODE_LOAD) && ld_ok;
    end
  end

  always_ff @(posedge clk) begin
    ri0_r  <= row_ext[RW-1:0];
    ci0_r  <= col_ext[CW-1:0];
    pix0_r <= {in_data.in_red, in_data.in_green, in_data.in_blue};
    dr0_r  <= dr_nxt;
    dc0_r  <= dc_nxt;
  end

  // Stage 1: the four rotation products.
  logic                     req1_r, wr1_r;
  logic [RW-1:0]            ri1_r;
  logic [CW-1:0]            ci1_r;
  logic [PIX_W-1:0]         pix1_r;
  logic signed [PROD_W-1:0] prc1_r, pcs1_r, pcc1_r, prs1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req1_r <= 1'b0;
      wr1_r  <= 1'b0;
    end else begin
      req1_r <= req0_r;
      wr1_r  <= wr0_r;
    end
  end

  always_ff @(posedge clk) begin
    ri1_r  <= ri0_r;
    ci1_r  <= ci0_r;
    pix1_r <= pix0_r;
    prc1_r <= PROD_W'(dr0_r) * PROD_W'(cfg.cos_q);
    pcs1_r <= PROD_W'(dc0_r) * PROD_W'(cfg.sin_q);
    pcc1_r <= PROD_W'(dc0_r) * PROD_W'(cfg.cos_q);
    prs1_r <= PROD_W'(dr0_r) * PROD_W'(cfg.sin_q);
  end

  // Stage 2: source coordinates in fixed point, source center added.
  logic                 req2_r, wr2_r;
  logic [RW-1:0]        ri2_r;
  logic [CW-1:0]        ci2_r;
  logic [PIX_W-1:0]     pix2_r;
  logic signed [SW-1:0] sx2_r, sy2_r;
  logic signed [SW-1:0] sx_nxt, sy_nxt, cx, cy;

  always_comb begin
    cx = {{(SW-F-9){1'b0}}, cfg.old_height[9:1], {F{1'b0}}};
    cy = {{(SW-F-9){1'b0}}, cfg.old_width[9:1], {F{1'b0}}};
    sx_nxt = {{(SW-PROD_W){prc1_r[PROD_W-1]}}, prc1_r}
           - {{(SW-PROD_W){pcs1_r[PROD_W-1]}}, pcs1_r} + cx;
    sy_nxt = {{(SW-PROD_W){pcc1_r[PROD_W-1]}}, pcc1_r}
           + {{(SW-PROD_W){prs1_r[PROD_W-1]}}, prs1_r} + cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req2_r <= 1'b0;
      wr2_r  <= 1'b0;
    end else begin
      req2_r <= req1_r;
      wr2_r  <= wr1_r;
    end
  end

  always_ff @(posedge clk) begin
    ri2_r  <= ri1_r;
    ci2_r  <= ci1_r;
    pix2_r <= pix1_r;
    sx2_r  <= sx_nxt;
    sy2_r  <= sy_nxt;
  end

  // Stage 3: truncate toward zero and check the bounds. A negative sum
  // truncates to zero only when its floor is minus one with a nonzero
  // fraction; any other negative sum lands outside.
  logic          xneg, yneg, xnear0, ynear0, xin, yin;
  logic [FW-1:0] xv, yv;
  logic [XW-1:0] xe;
  logic [YW-1:0] ye;
  irn_ctl_t      ctl3_r;
  logic [RW-1:0] xi3_r;
  logic [CW-1:0] yi3_r;
  logic [PIX_W-1:0] pix3_r;

  always_comb begin
    xneg   = sx2_r[SW-1];
    yneg   = sy2_r[SW-1];
    xnear0 = xneg && (&sx2_r[SW-1:F]) && (|sx2_r[F-1:0]);
    ynear0 = yneg && (&sy2_r[SW-1:F]) && (|sy2_r[F-1:0]);
    xv     = xneg ? '0 : sx2_r[SW-1:F];
    yv     = yneg ? '0 : sy2_r[SW-1:F];
    xe     = XW'(xv);
    ye     = YW'(yv);
    xin    = (!xneg || xnear0) && (xe < XW'(cfg.old_height))
             && (xe < XW'(MAX_SRC_ROWS));
    yin    = (!yneg || ynear0) && (ye < YW'(cfg.old_width))
             && (ye < YW'(MAX_SRC_COLS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else begin
      ctl3_r.req <= req2_r;
      ctl3_r.wr  <= wr2_r;
      ctl3_r.hit <= xin && yin;
    end
  end

  always_ff @(posedge clk) begin
    xi3_r  <= wr2_r ? ri2_r : xe[RW-1:0];
    yi3_r  <= wr2_r ? ci2_r : ye[CW-1:0];
    pix3_r <= pix2_r;
  end

  assign ctl_o   = ctl3_r;
  assign x_idx_o = xi3_r;
  assign y_idx_o = yi3_r;
  assign pix_o   = pix3_r;

endmodule

`default_nettype wire

// ===== rtl/image_rotate_nearest.sv =====
// A request beat accepted at a clock edge shows its result with out_valid after
// the map stages, the store read register and the output register; load beats produce no result.
// Throughput: one beat per cycle; busy never rises and the receiver cannot stall.
// The frame store is a single-port memory; loads and reads use it in the same
// pipeline stage, so a read always sees every load accepted before it.
// Reset clears the pipeline valid bits and loads CFG_RESET into the configuration; the store keeps data.
// ----------------------------------------------------------------------------
// image_rotate_nearest
// Nearest-neighbor rotation of an RGB image by inverse mapping into a frame store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "image_rotate_nearest_defines.svh"

module image_rotate_nearest import irn_pkg::*; #(
  parameter int MAX_SRC_ROWS   = 512,
  parameter int MAX_SRC_COLS   = 512,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire irn_in_t               in_data,
  output logic                       out_valid,
  output irn_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW = $clog2(MAX_SRC_ROWS);
  localparam int CW = $clog2(MAX_SRC_COLS);

  irn_cfg_t         cfg_r;
  irn_ctl_t         ctl;
  logic [RW-1:0]    x_idx;
  logic [CW-1:0]    y_idx;
  logic [PIX_W-1:0] pix;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_OLD_HEIGHT: cfg_r.old_height <= cfg_wdata[9:0];
        CFG_OLD_WIDTH:  cfg_r.old_width  <= cfg_wdata[9:0];
        CFG_NEW_HEIGHT: cfg_r.new_height <= cfg_wdata[10:0];
        CFG_NEW_WIDTH:  cfg_r.new_width  <= cfg_wdata[10:0];
        CFG_COS_Q:      cfg_r.cos_q      <= signed'(cfg_wdata);
        CFG_SIN_Q:      cfg_r.sin_q      <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  irn_map #(
    .MAX_SRC_ROWS   (MAX_SRC_ROWS),
    .MAX_SRC_COLS   (MAX_SRC_COLS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (start && !busy),
    .in_data (in_data),
    .cfg     (cfg_r),
    .ctl_o   (ctl),
    .x_idx_o (x_idx),
    .y_idx_o (y_idx),
    .pix_o   (pix)
  );

  // Frame store: one access per cycle, either a load or a read.
  logic [PIX_W-1:0] frame_mem [MAX_SRC_ROWS][MAX_SRC_COLS];
  logic [PIX_W-1:0] rd_data_r;
  logic             req4_r, ins4_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      frame_mem[x_idx][y_idx] <= pix;
    end
    rd_data_r <= frame_mem[x_idx][y_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req4_r <= 1'b0;
    end else begin
      req4_r <= ctl.req;
    end
  end

  always_ff @(posedge clk) begin
    ins4_r <= ctl.hit;
  end

  // Output register; a point outside the source image reads as black.
  logic     out_valid_r;
  irn_out_t out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt.out_blue   = ins4_r ? rd_data_r[7:0]   : 8'd0;
    out_data_nxt.out_green  = ins4_r ? rd_data_r[15:8]  : 8'd0;
    out_data_nxt.out_red    = ins4_r ? rd_data_r[23:16] : 8'd0;
    out_data_nxt.inside_res = ins4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= req4_r;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  logic req_acc, load_acc, bad_black;

  assign req_acc   = start && !busy && (in_data.mode == MODE_REQ);
  assign load_acc  = start && !busy && (in_data.mode == MODE_LOAD);
  assign bad_black = out_valid && !out_data.inside_res
                     && (|{out_data.out_blue, out_data.out_green, out_data.out_red});

  `IRN_ASSERT_IMPL(a_req_gives_result, req_acc, ##6 out_valid, "request beat gave no result")
  `IRN_ASSERT_IMPL(a_load_is_silent, load_acc, ##6 !out_valid, "load beat gave a result")
  `IRN_ASSERT_NEVER(a_outside_black, bad_black, "outside result is not black")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks image_rotate_nearest against a behavioral model of the rotation.
// A copy of the frame store and of the geometry registers predicts every
// requested pixel. Loads and requests are driven with random gaps. Each
// result strobe is compared field by field with the oldest prediction.
// Before a request that maps onto a store entry never written, a load of
// that entry is sent.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import irn_pkg::*;

  localparam int SRC_ROWS = 512;
  localparam int SRC_COLS = 512;
  localparam int FRAC_BITS = 14;
  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1650;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  irn_in_t               in_data = '0;
  logic                  out_valid;
  irn_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  irn_cfg_t         rot_cfg = CFG_RESET;
  logic [PIX_W-1:0] frame_copy [SRC_ROWS*SRC_COLS];
  bit               pixel_loaded [SRC_ROWS*SRC_COLS];
  irn_out_t         pixel_q [$];
  int               error_count = 0;
  int               beat_count = 0;
  bit               gapless = 1'b0;

  // Rotations by 0, 30, 45, 60, 90, 135, 180, 210, 270 and 315 degrees.
  int rot_cos [10] = '{16384, 14189, 11585, 8192, 0, -11585, -16384, -14189, 0, 11585};
  int rot_sin [10] = '{0, 8192, 11585, 14189, 16384, 11585, 0, -8192, -16384, -11585};

  image_rotate_nearest #(
    .MAX_SRC_ROWS  (SRC_ROWS),
    .MAX_SRC_COLS  (SRC_COLS),
    .TRIG_FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Inverse mapping of an output pixel; division truncates toward zero.
  function automatic bit map_to_source(input logic [9:0] row, input logic [9:0] col,
                                       output longint sx, output longint sy);
    longint dr;
    longint dc;
    dr = longint'(row) - longint'(rot_cfg.new_height >> 1);
    dc = longint'(col) - longint'(rot_cfg.new_width >> 1);
    sx = (dr * longint'($signed(rot_cfg.cos_q)) - dc * longint'($signed(rot_cfg.sin_q))
          + (longint'(rot_cfg.old_height >> 1) << FRAC_BITS)) / FRAC_ONE;
    sy = (dc * longint'($signed(rot_cfg.cos_q)) + dr * longint'($signed(rot_cfg.sin_q))
          + (longint'(rot_cfg.old_width >> 1) << FRAC_BITS)) / FRAC_ONE;
    return sx >= 0 && sx < longint'(rot_cfg.old_height) && sx < SRC_ROWS
        && sy >= 0 && sy < longint'(rot_cfg.old_width) && sy < SRC_COLS;
  endfunction

  function automatic irn_in_t make_beat(input logic mode, input int row, input int col,
                                        input logic [PIX_W-1:0] px);
    irn_in_t b;
    b.mode     = mode;
    b.row      = 10'(row);
    b.col      = 10'(col);
    b.in_blue  = px[7:0];
    b.in_green = px[15:8];
    b.in_red   = px[23:16];
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gapless || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Called at a rising edge; returns at the edge that accepted the beat,
  // or after the idle gap that follows it.
  task automatic send_beat(input irn_in_t beat);
    longint           sx;
    longint           sy;
    bit               hit;
    int               idx;
    int               gap;
    logic [PIX_W-1:0] px;
    logic [63:0]      noise;
    irn_out_t         pred;
    start   <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    if (beat.mode == MODE_LOAD) begin
      if (beat.row < SRC_ROWS && beat.col < SRC_COLS) begin
        idx = int'(beat.row) * SRC_COLS + int'(beat.col);
        frame_copy[idx]   = {beat.in_red, beat.in_green, beat.in_blue};
        pixel_loaded[idx] = 1'b1;
        beat_count++;
      end
    end else begin
      hit = map_to_source(beat.row, beat.col, sx, sy);
      px = hit ? frame_copy[int'(sx) * SRC_COLS + int'(sy)] : '0;
      pred.out_blue   = px[7:0];
      pred.out_green  = px[15:8];
      pred.out_red    = px[23:16];
      pred.inside_res = hit;
      pixel_q = {pixel_q, pred};
      beat_count++;
    end
    gap = pick_gap();
    if (gap > 0) begin
      noise   = {$urandom, $urandom};
      start   <= 1'b0;
      in_data <= noise[$bits(irn_in_t)-1:0];
      repeat (gap) @(posedge clk);
    end
  endtask

  // A request that would hit a store entry never written gets that entry loaded first.
  task automatic send_request(input int row, input int col);
    longint sx;
    longint sy;
    bit     hit;
    hit = map_to_source(10'(row), 10'(col), sx, sy);
    if (hit && !pixel_loaded[int'(sx) * SRC_COLS + int'(sy)])
      send_beat(make_beat(MODE_LOAD, int'(sx), int'(sy), PIX_W'($urandom)));
    send_beat(make_beat(MODE_REQ, row, col, PIX_W'($urandom)));
  endtask

  // Always advances at least one edge, so start is never assigned twice in one step.
  task automatic wait_idle(input int settle);
    start <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data      = CFG_DATA_W'(value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OLD_HEIGHT: rot_cfg.old_height = data[9:0];
      CFG_OLD_WIDTH:  rot_cfg.old_width  = data[9:0];
      CFG_NEW_HEIGHT: rot_cfg.new_height = data[10:0];
      CFG_NEW_WIDTH:  rot_cfg.new_width  = data[10:0];
      CFG_COS_Q:      rot_cfg.cos_q      = data;
      CFG_SIN_Q:      rot_cfg.sin_q      = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Unused high bits of the narrow registers carry junk, which must be dropped.
  task automatic set_geometry(input int oh, input int ow, input int nh, input int nw,
                              input int cq, input int sq);
    wait_idle(SETTLE_CYCLES);
    write_register(CFG_OLD_HEIGHT, oh | (int'($urandom_range(0, 63)) << 10));
    write_register(CFG_OLD_WIDTH, ow | (int'($urandom_range(0, 63)) << 10));
    write_register(CFG_NEW_HEIGHT, nh | (int'($urandom_range(0, 31)) << 11));
    write_register(CFG_NEW_WIDTH, nw | (int'($urandom_range(0, 31)) << 11));
    write_register(CFG_COS_Q, cq);
    write_register(CFG_SIN_Q, sq);
  endtask

  task automatic test_identity_corners();
    send_beat(make_beat(MODE_LOAD, 0, 0, 24'h000000));
    send_beat(make_beat(MODE_LOAD, 511, 511, 24'hffffff));
    send_beat(make_beat(MODE_LOAD, 0, 511, 24'h5aa53c));
    send_beat(make_beat(MODE_LOAD, 511, 0, PIX_W'($urandom)));
    send_request(0, 0);
    send_request(511, 511);
    send_request(0, 511);
    send_request(511, 0);
    send_request(512, 0);
    send_request(1023, 1023);
  endtask

  // Loads past the store must not alias onto the low rows or columns.
  task automatic test_store_bounds();
    send_beat(make_beat(MODE_LOAD, 0, 3, PIX_W'($urandom)));
    send_beat(make_beat(MODE_LOAD, 512, 3, PIX_W'($urandom)));
    send_beat(make_beat(MODE_LOAD, 3, 0, PIX_W'($urandom)));
    send_beat(make_beat(MODE_LOAD, 3, 512, PIX_W'($urandom)));
    send_beat(make_beat(MODE_LOAD, 1023, 1023, PIX_W'($urandom)));
    send_request(0, 3);
    send_request(3, 0);
  endtask

  task automatic test_register_edges();
    // Source taller than the store: rows past the store read as outside.
    wait_idle(SETTLE_CYCLES);
    write_register(CFG_OLD_HEIGHT, 1023);
    send_request(600, 10);
    send_request(0, 0);
    // An empty source answers every request as outside.
    wait_idle(SETTLE_CYCLES);
    write_register(CFG_OLD_HEIGHT, 0);
    write_register(CFG_SPARE_LO, int'($urandom));
    write_register(CFG_SPARE_HI, int'($urandom));
    send_request(256, 256);
    // Half a row above the center truncates to row 0; one and a half rows to -1.
    set_geometry(1, 1, 512, 512, 8192, 0);
    send_request(255, 256);
    send_request(253, 256);
    set_geometry(512, 512, 2047, 2047, -32768, 32767);
    send_request(0, 0);
    send_request(1023, 1023);
    set_geometry(512, 512, 1024, 1024, 16384, -16384);
    send_request(1023, 0);
  endtask

  task automatic test_random_rotations();
    int goal;
    int phase;
    int kind;
    int pick;
    int oh, ow, nh, nw, cq, sq;
    int n_req;
    goal  = beat_count + RANDOM_ITEMS;
    phase = 0;
    while (beat_count < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        oh = $urandom_range(1, 16);
        ow = $urandom_range(1, 16);
        nh = $urandom_range(1, 40);
        nw = $urandom_range(1, 40);
      end else if (kind < 95) begin
        oh = $urandom_range(1, 128);
        ow = $urandom_range(1, 128);
        nh = $urandom_range(1, 256);
        nw = $urandom_range(1, 256);
      end else begin
        oh = 512;
        ow = 512;
        nh = $urandom_range(0, 1) ? 1024 : $urandom_range(512, 1024);
        nw = $urandom_range(0, 1) ? 1024 : $urandom_range(512, 1024);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        pick = $urandom_range(0, 9);
        cq = rot_cos[pick];
        sq = rot_sin[pick];
      end else if (pick < 8) begin
        cq = int'($urandom_range(0, 32768)) - 16384;
        sq = int'($urandom_range(0, 32768)) - 16384;
      end else begin
        cq = int'($urandom);
        sq = int'($urandom);
      end
      set_geometry(oh, ow, nh, nw, cq, sq);
      gapless = ($urandom_range(0, 3) == 0);
      if (oh * ow <= 256) begin
        for (int r = 0; r < oh; r++)
          for (int c = 0; c < ow; c++)
            send_beat(make_beat(MODE_LOAD, r, c, PIX_W'($urandom)));
      end
      n_req = $urandom_range(20, 60);
      for (int i = 0; i < n_req; i++) begin
        // Now and then hold the next beat until every pending pixel is back.
        if (i == n_req / 2 && phase % 4 == 1)
          wait_idle(1);
        if ($urandom_range(0, 19) == 0)
          send_beat(make_beat(MODE_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                              PIX_W'($urandom)));
        if ($urandom_range(0, 9) < 8)
          send_request($urandom_range(0, nh - 1), $urandom_range(0, nw - 1));
        else
          send_request($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      phase++;
    end
    gapless = 1'b0;
  endtask

  always @(posedge clk) begin
    irn_out_t want;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: pixel %h with none expected", $time, out_data);
        error_count++;
      end else begin
        want = pixel_q.pop_front();
        check_field("out_blue", want.out_blue, out_data.out_blue);
        check_field("out_green", want.out_green, out_data.out_green);
        check_field("out_red", want.out_red, out_data.out_red);
        check_field("inside_res", {7'd0, want.inside_res}, {7'd0, out_data.inside_res});
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_corners();
    test_store_bounds();
    test_register_edges();
    test_random_rotations();
    wait_idle(SETTLE_CYCLES);
    if (error_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
